/* rtl/cft_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cft_pkg
// Shared types, character codes and the unescape helper of the csv field tokenizer.
// ----------------------------------------------------------------------------
package cft_pkg;

  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_BSL      = 8'h5C;
  localparam logic [7:0] CH_N        = 8'h6E;
  localparam logic [7:0] CH_T        = 8'h74;
  localparam logic [7:0] DELIM_RESET = 8'h2C;

  typedef enum logic [2:0] {
    ST_BETWEEN = 3'd0,
    ST_QUOTED  = 3'd1,
    ST_QUOTE1  = 3'd2,
    ST_QESC    = 3'd3,
    ST_SIMPLE  = 3'd4,
    ST_SESC    = 3'd5
  } parse_state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       field_end;
    logic       line_end;
    logic       input_done;
  } result_t;

  typedef struct packed {
    logic         emit;
    result_t      res;
    parse_state_t state;
    logic         line_has_field;
  } step_t;

  function automatic logic [7:0] unescape(input logic [7:0] c);
    logic [7:0] d;
    d = c;
    if (c == CH_N) begin
      d = CH_LF;
    end else if (c == CH_T) begin
      d = CH_TAB;
    end
    return d;
  endfunction

endpackage
`default_nettype wire

/* rtl/cft_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cft_if
// Valid/ready channels for raw input items and tokenizer result items.
// ----------------------------------------------------------------------------
interface cft_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] in_byte;

  modport source (output valid, output req_type, output in_byte, input ready);
  modport sink   (input valid, input req_type, input in_byte, output ready);
endinterface

interface cft_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       field_end;
  logic       line_end;
  logic       input_done;

  modport source (output valid, output out_byte, output byte_valid, output field_end,
                  output line_end, output input_done, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input field_end,
                  input line_end, input input_done, output ready);
endinterface
`default_nettype wire

/* rtl/cft_step.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cft_step
// Next-state and result logic of the tokenizer for one input item.
// ----------------------------------------------------------------------------
module cft_step (
  input  wire cft_pkg::parse_state_t state,
  input  wire                        line_has_field,
  input  wire                        req_type,
  input  wire [7:0]                  c,
  input  wire [7:0]                  delimiter,
  output cft_pkg::step_t             step
);
  import cft_pkg::*;

  always_comb begin
    step                = '0;
    step.state          = state;
    step.line_has_field = line_has_field;
    if (req_type) begin
      step.emit           = 1'b1;
      step.res.input_done = 1'b1;
      if (state == ST_QUOTED || state == ST_QUOTE1 || state == ST_QESC ||
          state == ST_SIMPLE || state == ST_SESC) begin
        step.res.field_end = 1'b1;
        step.res.line_end  = 1'b1;
      end else if (line_has_field) begin
        step.res.line_end = 1'b1;
      end
      step.state          = ST_BETWEEN;
      step.line_has_field = 1'b0;
    end else begin
      unique case (state)
        ST_QUOTED: begin
          priority if (c == CH_QUOTE) begin
            step.state = ST_QUOTE1;
          end else if (c == CH_BSL) begin
            step.state = ST_QESC;
          end else begin
            step.emit           = 1'b1;
            step.res.out_byte   = c;
            step.res.byte_valid = 1'b1;
          end
        end
        ST_QUOTE1: begin
          priority if (c == CH_LF) begin
            step.emit           = 1'b1;
            step.res.field_end  = 1'b1;
            step.res.line_end   = 1'b1;
            step.state          = ST_BETWEEN;
            step.line_has_field = 1'b0;
          end else if (c == CH_QUOTE) begin
            step.emit           = 1'b1;
            step.res.out_byte   = c;
            step.res.byte_valid = 1'b1;
            step.state          = ST_QUOTED;
          end else if (c == CH_CR) begin
            step.state = ST_SIMPLE;
          end else if (c == delimiter) begin
            step.emit           = 1'b1;
            step.res.field_end  = 1'b1;
            step.state          = ST_BETWEEN;
            step.line_has_field = 1'b1;
          end else begin
            step.emit           = 1'b1;
            step.res.out_byte   = c;
            step.res.byte_valid = 1'b1;
            step.state          = ST_SIMPLE;
          end
        end
        ST_QESC: begin
          step.emit           = 1'b1;
          step.res.out_byte   = unescape(c);
          step.res.byte_valid = 1'b1;
          step.state          = ST_QUOTED;
        end
        ST_SIMPLE: begin
          priority if (c == CH_LF) begin
            step.emit           = 1'b1;
            step.res.field_end  = 1'b1;
            step.res.line_end   = 1'b1;
            step.state          = ST_BETWEEN;
            step.line_has_field = 1'b0;
          end else if (c == CH_CR) begin
            step.state = ST_SIMPLE;
          end else if (c == CH_BSL) begin
            step.state = ST_SESC;
          end else if (c == delimiter) begin
            step.emit           = 1'b1;
            step.res.field_end  = 1'b1;
            step.state          = ST_BETWEEN;
            step.line_has_field = 1'b1;
          end else begin
            step.emit           = 1'b1;
            step.res.out_byte   = c;
            step.res.byte_valid = 1'b1;
          end
        end
        ST_SESC: begin
          step.emit           = 1'b1;
          step.res.out_byte   = unescape(c);
          step.res.byte_valid = 1'b1;
          step.state          = ST_SIMPLE;
        end
        default: begin
          priority if (c == CH_LF) begin
            step.emit           = 1'b1;
            step.res.field_end  = 1'b1;
            step.res.line_end   = 1'b1;
            step.state          = ST_BETWEEN;
            step.line_has_field = 1'b0;
          end else if (c == CH_CR) begin
            step.state = ST_BETWEEN;
          end else if (c == CH_QUOTE) begin
            step.state = ST_QUOTED;
          end else if (c == CH_BSL) begin
            step.state = ST_SESC;
          end else if (c == delimiter) begin
            step.emit           = 1'b1;
            step.res.field_end  = 1'b1;
            step.state          = ST_BETWEEN;
            step.line_has_field = 1'b1;
          end else begin
            step.emit           = 1'b1;
            step.res.out_byte   = c;
            step.res.byte_valid = 1'b1;
            step.state          = ST_SIMPLE;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/csv_field_tokenizer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csv_field_tokenizer
// Streaming csv tokenizer: one raw byte or end-of-input marker per item,
// at most one field byte, or any of field end, line end and done mark, per result.
// ----------------------------------------------------------------------------
// path: an accepted item waits in the input register until the result register is free
// or drained; throughput: one item per cycle while it is, through the combinational parse step
// between the input register and the result register
// reset: synchronous active-low rst_n clears both registers' valid flags,
// the parse state and sets the delimiter to ','
module csv_field_tokenizer (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        cfg_we,
  input  wire [7:0]  cfg_wdata,
  cft_in_if.sink     in_chan,
  cft_out_if.source  out_chan
);
  import cft_pkg::*;

  logic         in_valid_r;
  logic         in_req_r;
  logic [7:0]   in_byte_r;
  logic         out_valid_r;
  result_t      out_res_r;
  parse_state_t state_r;
  logic         line_has_field_r;
  logic [7:0]   delimiter_r;

  logic         advance;
  logic         in_ready;
  step_t        step_nxt;

  assign advance  = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_ready = !in_valid_r || advance;

  cft_step u_step (
    .state          (state_r),
    .line_has_field (line_has_field_r),
    .req_type       (in_req_r),
    .c              (in_byte_r),
    .delimiter      (delimiter_r),
    .step           (step_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      state_r          <= ST_BETWEEN;
      line_has_field_r <= 1'b0;
      delimiter_r      <= DELIM_RESET;
    end else begin
      if (cfg_we) begin
        delimiter_r <= cfg_wdata;
      end
      if (in_ready) begin
        in_valid_r <= in_chan.valid;
      end
      if (advance) begin
        out_valid_r      <= step_nxt.emit;
        state_r          <= step_nxt.state;
        line_has_field_r <= step_nxt.line_has_field;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_chan.valid) begin
      in_req_r  <= in_chan.req_type;
      in_byte_r <= in_chan.in_byte;
    end
    if (advance) begin
      out_res_r <= step_nxt.res;
    end
  end

  assign in_chan.ready       = in_ready;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.out_byte   = out_res_r.out_byte;
  assign out_chan.byte_valid = out_res_r.byte_valid;
  assign out_chan.field_end  = out_res_r.field_end;
  assign out_chan.line_end   = out_res_r.line_end;
  assign out_chan.input_done = out_res_r.input_done;

endmodule
`default_nettype wire
